>>> sv/linear_probe_hash_table_core_macros.svh
// Assertion macros for the linear-probe hash table checker.
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define LPHT_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on clock edges while reset is held.
`define LPHT_CHECK_IN_RESET(label, prop, msg) \
	label: assert property (@(posedge clk) !arst_n |-> prop) else $error(msg);

`endif

>>> sv/lpht_pkg.sv
// Shared types and constants of the linear-probe hash table.
`default_nettype none
package lpht_pkg;
	localparam int KEY_W    = 32;
	localparam int SLOT_W   = 10;
	localparam int STATUS_W = 2;

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_FIND   = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_FOUND    = 2'd2,
		ST_MISSING  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} res_t;
endpackage
`default_nettype wire

>>> sv/lpht_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lpht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

>>> sv/lpht_fifo.sv
// Small register FIFO used between the stages and on the result side.
`default_nettype none
module lpht_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end
endmodule
`default_nettype wire

>>> sv/lpht_front.sv
// Front stage: takes requests and reduces each key to its home slot.
`default_nettype none
module lpht_front import lpht_pkg::*; #(
	parameter int NUM_BUCKETS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clearing,
	input  logic                           push,
	output logic                           full,
	input  logic                           cmd,
	input  logic [KEY_W-1:0]               key,
	output logic                           q_push,
	input  logic                           q_full,
	output req_t                           q_req,
	output logic [$clog2(NUM_BUCKETS)-1:0] q_home
);
	localparam int AW  = $clog2(NUM_BUCKETS);
	localparam int PW  = 2 * KEY_W;
	localparam int PW1 = PW + 1;
	localparam int SH  = KEY_W + AW;
	// 2^SH / NUM_BUCKETS rounded up; it always lies in [2^KEY_W, 2^(KEY_W+1)).
	localparam logic [PW:0] RECIP =
		((PW1'(1) << SH) + PW1'(NUM_BUCKETS - 1)) / PW1'(NUM_BUCKETS);
	localparam logic [KEY_W-1:0] RECIP_LO = RECIP[KEY_W-1:0];
	localparam logic [AW-1:0]    NB_LO    = AW'(NUM_BUCKETS);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_RED  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t          state_q;
	cmd_t             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [PW-1:0]    prod_q;
	logic [AW-1:0]    rem_q;
	logic [PW:0]      scaled;
	logic [AW-1:0]    quo_lo;
	logic [AW-1:0]    quo_n;
	logic [AW-1:0]    rem_next;
	logic             take;

	assign full   = (state_q != F_IDLE) || clearing;
	assign take   = push && !full;
	assign q_push = (state_q == F_PUSH) && !q_full;
	assign q_req  = '{cmd: cmd_q, key: key_q};
	assign q_home = rem_q;

	// Add back the top bit of the reciprocal as key << KEY_W.
	assign scaled   = {1'b0, key_q, {KEY_W{1'b0}}} + {1'b0, prod_q};
	assign quo_lo   = scaled[SH +: AW];
	assign quo_n    = quo_lo * NB_LO;
	// The remainder is below 2^AW, so only the low bits of key - quotient * N matter.
	assign rem_next = key_q[AW-1:0] - quo_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (take) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_RED;
				end
				F_RED: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd_t'(cmd);
			key_q <= key;
		end
		if (state_q == F_MUL) begin
			prod_q <= PW'(key_q) * PW'(RECIP_LO);
		end
		if (state_q == F_RED) begin
			rem_q <= rem_next;
		end
	end
endmodule
`default_nettype wire

>>> sv/lpht_back.sv
// Back stage: clears the slot RAM after reset, then probes it for each request.
`default_nettype none
module lpht_back import lpht_pkg::*; #(
	parameter int NUM_BUCKETS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	output logic                           clearing,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  req_t                           q_req,
	input  logic [$clog2(NUM_BUCKETS)-1:0] q_home,
	input  logic                           r_full,
	output logic                           r_push,
	output res_t                           r_res
);
	localparam int AW    = $clog2(NUM_BUCKETS);
	localparam int CNT_W = $clog2(NUM_BUCKETS + 1);

	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE  = 3'b010,
		B_PROBE = 3'b100
	} bstate_t;

	bstate_t          state_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] issued_q;
	logic             rdv_s1;
	logic             last_s1;
	logic [AW-1:0]    slot_s1;
	cmd_t             cmd_q;
	logic [KEY_W-1:0] key_q;

	logic             issue;
	logic             hit;
	logic             finish;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [KEY_W-1:0] ram_wdata;
	logic [KEY_W-1:0] ram_rdata;
	logic [AW-1:0]    addr_inc;

	assign clearing = (state_q == B_CLEAR);
	// Start a request only when the result queue has room for its answer.
	assign q_pop    = (state_q == B_IDLE) && !q_empty && !r_full;
	assign issue    = (state_q == B_PROBE) && (issued_q != CNT_W'(NUM_BUCKETS));
	assign addr_inc = (addr_q == AW'(NUM_BUCKETS - 1)) ? '0 : addr_q + 1'b1;

	assign hit    = rdv_s1 && ((cmd_q == CMD_FIND) ? (ram_rdata == key_q)
	                                               : (ram_rdata == '0));
	assign finish = (state_q == B_PROBE) && rdv_s1 && (hit || last_s1);
	assign r_push = finish;

	always_comb begin
		r_res.slot = hit ? SLOT_W'(slot_s1) : '0;
		case (cmd_q)
			CMD_INSERT: r_res.status = hit ? ST_INSERTED : ST_FULL;
			CMD_FIND:   r_res.status = hit ? ST_FOUND : ST_MISSING;
			default:    r_res.status = ST_MISSING;
		endcase
	end

	assign ram_we    = clearing || (finish && hit && cmd_q == CMD_INSERT);
	assign ram_waddr = clearing ? addr_q : slot_s1;
	assign ram_wdata = clearing ? '0 : key_q;

	lpht_ram #(
		.WIDTH(KEY_W),
		.DEPTH(NUM_BUCKETS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_CLEAR;
			addr_q   <= '0;
			issued_q <= '0;
			rdv_s1   <= 1'b0;
		end else begin
			rdv_s1 <= issue;
			case (state_q)
				B_CLEAR: begin
					addr_q <= addr_inc;
					if (addr_q == AW'(NUM_BUCKETS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_pop) begin
						addr_q   <= q_home;
						issued_q <= '0;
						state_q  <= B_PROBE;
					end
				end
				B_PROBE: begin
					if (issue) begin
						addr_q   <= addr_inc;
						issued_q <= issued_q + 1'b1;
					end
					if (finish) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= addr_q;
		last_s1 <= (issued_q == CNT_W'(NUM_BUCKETS - 1));
		if (q_pop) begin
			cmd_q <= q_req.cmd;
			key_q <= q_req.key;
		end
	end
endmodule
`default_nettype wire

>>> sv/linear_probe_hash_table_core.sv
// Top level of the linear-probe hash table.
// Open-addressing hash table of NUM_BUCKETS 32-bit key slots with linear probing;
// a zero key marks an empty slot. Requests (cmd 0 insert, 1 find) enter through a
// push/full queue port and answers (status, slot) leave through an empty/pop
// queue port, one answer per request, in request order. The front stage reduces
// the key to its home slot by a multiply with the reciprocal of NUM_BUCKETS, in the
// states MUL and RED, and takes no new request until PUSH has passed it on. The back
// stage reads the slot RAM once per cycle along the probe sequence and answers when
// an insert finds the first empty slot, a find the first match, or a miss has read all
// slots; it then takes the next request from the queue between the stages, and the
// front works on the next key meanwhile. After reset the RAM is cleared one slot a
// cycle while full stays high.
`default_nettype none
module linear_probe_hash_table_core import lpht_pkg::*; #(
	parameter int NUM_BUCKETS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic                cmd,
	input  logic [KEY_W-1:0]    key,
	output logic                empty,
	input  logic                pop,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot
);
	localparam int AW    = $clog2(NUM_BUCKETS);
	localparam int MID_W = $bits(req_t) + AW;

	logic          clearing;
	logic          f_push;
	logic          f_full;
	req_t          f_req;
	logic [AW-1:0] f_home;
	logic          b_pop;
	logic          b_empty;
	req_t          b_req;
	logic [AW-1:0] b_home;
	logic          r_push;
	logic          r_full;
	res_t          r_res;
	res_t          o_res;

	lpht_front #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.clearing(clearing),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.key     (key),
		.q_push  (f_push),
		.q_full  (f_full),
		.q_req   (f_req),
		.q_home  (f_home)
	);

	lpht_fifo #(
		.WIDTH(MID_W),
		.DEPTH(2)
	) u_mid_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.full  (f_full),
		.wdata ({f_req, f_home}),
		.pop   (b_pop),
		.empty (b_empty),
		.rdata ({b_req, b_home})
	);

	lpht_back #(
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.clearing(clearing),
		.q_empty (b_empty),
		.q_pop   (b_pop),
		.q_req   (b_req),
		.q_home  (b_home),
		.r_full  (r_full),
		.r_push  (r_push),
		.r_res   (r_res)
	);

	lpht_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(2)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (r_push),
		.full  (r_full),
		.wdata (r_res),
		.pop   (pop),
		.empty (empty),
		.rdata (o_res)
	);

	assign status = o_res.status;
	assign slot   = o_res.slot;
endmodule
`default_nettype wire

>>> sv/lpht_checker.sv
// Port-level checks of the linear-probe hash table, bound to the top level.
`default_nettype none
`include "linear_probe_hash_table_core_macros.svh"
module lpht_checker import lpht_pkg::*; #(
	parameter int NUM_BUCKETS = 10
) (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input logic [STATUS_W-1:0] status,
	input logic [SLOT_W-1:0]   slot
);
	// Requests taken whose answers are not yet popped.
	logic [2:0] outstanding_q;
	logic       req_in;
	logic       res_out;

	assign req_in  = push && !full;
	assign res_out = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (req_in && !res_out) begin
			outstanding_q <= outstanding_q + 1'b1;
		end else if (res_out && !req_in) begin
			outstanding_q <= outstanding_q - 1'b1;
		end
	end

	`LPHT_CHECK_IN_RESET(a_reset_idle, empty && full, "no answer and no intake during reset")
	`LPHT_CHECK(a_no_stray_result, (outstanding_q == '0) |-> empty, "answer without a request")
	`LPHT_CHECK(a_slot_range, !empty |-> (int'(slot) < NUM_BUCKETS), "slot beyond table")
	`LPHT_CHECK(a_miss_slot_zero, (!empty && (status == ST_FULL || status == ST_MISSING)) |-> (slot == '0), "miss must report slot zero")
	`LPHT_CHECK(a_result_holds, (!empty && !pop) |=> !empty, "waiting answer withdrawn")
endmodule

bind linear_probe_hash_table_core lpht_checker #(
	.NUM_BUCKETS(NUM_BUCKETS)
) u_lpht_checker (.*);
`default_nettype wire
